// ===== hdl/sdmb_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmb_pkg: shared types and constants of the SD multi-block sequencer
// Command, status and mode codes, the payload structs that travel between
// the stages, and the helper that forms the card command argument.
// ----------------------------------------------------------------------------
`default_nettype none

package sdmb_pkg;

   // Event codes carried by the request channel.
   localparam logic [2:0] CMD_START_WRITE = 3'd0;
   localparam logic [2:0] CMD_START_READ  = 3'd1;
   localparam logic [2:0] CMD_BLOCK_DONE  = 3'd2;
   localparam logic [2:0] CMD_XFER_ERROR  = 3'd3;
   localparam logic [2:0] CMD_RESET       = 3'd4;

   // Status codes returned with each response.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ARG_ERROR = 2'd1;
   localparam logic [1:0] ST_BUSY      = 2'd2;
   localparam logic [1:0] ST_NO_ACTION = 2'd3;

   // Mode codes as shown on the response channel.
   localparam logic [2:0] MODE_CODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_CODE_SENDING = 3'd1;
   localparam logic [2:0] MODE_CODE_READING = 3'd2;
   localparam logic [2:0] MODE_CODE_FINISH  = 3'd3;
   localparam logic [2:0] MODE_CODE_ERROR   = 3'd4;

   // Byte addressing multiplies the block number by 512.
   localparam int unsigned ARG_SHIFT = 9;

   // Internal one-hot transfer mode.
   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_SENDING = 5'b00010,
      MODE_READING = 5'b00100,
      MODE_FINISH  = 5'b01000,
      MODE_ERROR   = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] buffer_address;
      logic [31:0] block_address;
      logic [31:0] block_count;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        issue_block;
      logic        issue_write;
      logic [31:0] command_argument;
      logic [31:0] dma_base;
      logic        transfer_finished;
      logic [2:0]  mode_now;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] card_block_count;
      logic        standard_capacity;
   } cfg_type;

   // Card address argument: scaled to bytes on standard-capacity cards, wrapping
   // to 32 bits.
   function automatic logic [31:0] card_argument(input logic [31:0] blk,
                                                 input logic        std_cap);
      card_argument = std_cap ? (blk << ARG_SHIFT) : blk;
   endfunction

   // Map the one-hot mode to its external code.
   function automatic logic [2:0] mode_code(input mode_type m);
      unique case (m)
         MODE_IDLE:    mode_code = MODE_CODE_IDLE;
         MODE_SENDING: mode_code = MODE_CODE_SENDING;
         MODE_READING: mode_code = MODE_CODE_READING;
         MODE_FINISH:  mode_code = MODE_CODE_FINISH;
         MODE_ERROR:   mode_code = MODE_CODE_ERROR;
         default:      mode_code = MODE_CODE_IDLE;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sdmb_in_stage.sv =====
// ----------------------------------------------------------------------------
// sdmb_in_stage: request input register
// Captures one request transfer and holds it until the sequencing stage
// consumes it; stalls the request side only while it is full and blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmb_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sdmb_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output sdmb_pkg::req_item_type     item
);
   import sdmb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // The register may take a new transfer when empty or when it drains now.
   assign load      = !valid_ff || advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hdl/sdmb_core.sv =====
// ----------------------------------------------------------------------------
// sdmb_core: transfer sequencing state and response logic
// Holds the mode, remaining count, card block and buffer address, and forms
// the response for the event in the input register in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmb_core #(
   parameter int unsigned BLOCK_BYTES = 512
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sdmb_pkg::cfg_type      cfg,
   input  wire logic                   fire,
   input  wire sdmb_pkg::req_item_type item,
   output sdmb_pkg::rsp_item_type      result
);
   import sdmb_pkg::*;

   localparam logic [31:0] BUFFER_STEP = 32'(BLOCK_BYTES);

   mode_type    mode_ff,      mode_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] block_ff,     block_in;
   logic [31:0] buffer_ff,    buffer_in;

   logic [32:0] range_end;
   logic        arg_bad;
   logic        busy;
   logic        issue;
   logic        finished;
   logic [1:0]  status;

   // Start checks: the range end is formed one bit wider so it cannot wrap.
   assign range_end = {1'b0, item.block_address} + {1'b0, item.block_count};
   assign arg_bad   = (item.buffer_address == 32'd0) || (item.block_count == 32'd0) ||
                      (range_end > {1'b0, cfg.card_block_count});
   assign busy      = !((mode_ff == MODE_IDLE) || (mode_ff == MODE_FINISH));

   // Next state and response flags for the current event.
   always_comb begin
      mode_in      = mode_ff;
      remaining_in = remaining_ff;
      block_in     = block_ff;
      buffer_in    = buffer_ff;
      issue        = 1'b0;
      finished     = 1'b0;
      status       = ST_NO_ACTION;
      unique case (item.command)
         CMD_START_WRITE, CMD_START_READ: begin
            if (arg_bad) begin
               status = ST_ARG_ERROR;
            end else if (busy) begin
               status = ST_BUSY;
            end else begin
               mode_in      = (item.command == CMD_START_WRITE) ? MODE_SENDING
                                                                 : MODE_READING;
               remaining_in = item.block_count;
               block_in     = item.block_address;
               buffer_in    = item.buffer_address;
               issue        = 1'b1;
               status       = ST_OK;
            end
         end
         CMD_BLOCK_DONE: begin
            if ((mode_ff == MODE_SENDING) || (mode_ff == MODE_READING)) begin
               if (remaining_ff <= 32'd1) begin
                  remaining_in = 32'd0;
                  block_in     = 32'd0;
                  buffer_in    = 32'd0;
                  mode_in      = MODE_FINISH;
                  finished     = 1'b1;
               end else begin
                  remaining_in = remaining_ff - 32'd1;
                  block_in     = block_ff + 32'd1;
                  buffer_in    = buffer_ff + BUFFER_STEP;
                  issue        = 1'b1;
               end
               status = ST_OK;
            end
         end
         CMD_XFER_ERROR: begin
            mode_in = MODE_ERROR;
            status  = ST_OK;
         end
         CMD_RESET: begin
            mode_in      = MODE_IDLE;
            remaining_in = 32'd0;
            block_in     = 32'd0;
            buffer_in    = 32'd0;
            status       = ST_OK;
         end
         default: begin
            status = ST_NO_ACTION;
         end
      endcase
   end

   // Response fields; issue fields read as zero when no block is issued.
   always_comb begin
      result.status            = status;
      result.issue_block       = issue;
      result.issue_write       = issue && (mode_in == MODE_SENDING);
      result.command_argument  = issue ? card_argument(block_in, cfg.standard_capacity)
                                       : 32'd0;
      result.dma_base          = issue ? buffer_in : 32'd0;
      result.transfer_finished = finished;
      result.mode_now          = mode_code(mode_in);
   end

   // State advances only when an event moves on to the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         remaining_ff <= 32'd0;
         block_ff     <= 32'd0;
         buffer_ff    <= 32'd0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         remaining_ff <= remaining_in;
         block_ff     <= block_in;
         buffer_ff    <= buffer_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sdmb_out_stage.sv =====
// ----------------------------------------------------------------------------
// sdmb_out_stage: response output register
// Holds one response until the receiver takes it and tells the earlier
// stage when the pipeline may advance.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmb_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  wire sdmb_pkg::rsp_item_type result,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sdmb_pkg::rsp_item_type      rsp_item
);
   import sdmb_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // The register accepts a new response when empty or being taken now.
   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? item_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

// ===== hdl/sd_multiblock_dma_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// sd_multiblock_dma_sequencer_unit: SD multi-block transfer sequencer
// A request transfer passes the input register, then the response register.
// Throughput: one event per cycle while the receiver does not stall, set by
// the single-pass state update.
// Reset: synchronous; clears mode, counters, addresses and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_multiblock_dma_sequencer_unit #(
   parameter int unsigned BLOCK_BYTES = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [31:0] req_buffer_address,
   input  wire logic [31:0] req_block_address,
   input  wire logic [31:0] req_block_count,
   // Response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic             rsp_issue_block,
   output logic             rsp_issue_write,
   output logic [31:0]      rsp_command_argument,
   output logic [31:0]      rsp_dma_base,
   output logic             rsp_transfer_finished,
   output logic [2:0]       rsp_mode_now,
   // Configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import sdmb_pkg::*;

   localparam logic CSR_CARD_BLOCKS = 1'b0;
   localparam logic CSR_STD_CAP     = 1'b1;

   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         advance;
   rsp_item_type result;
   rsp_item_type rsp_item;
   cfg_type      cfg_ff;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CARD_BLOCKS: cfg_ff.card_block_count  <= csr_data;
            CSR_STD_CAP:     cfg_ff.standard_capacity <= csr_data[0];
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req_item.command        = req_command;
   assign req_item.buffer_address = req_buffer_address;
   assign req_item.block_address  = req_block_address;
   assign req_item.block_count    = req_block_count;

   sdmb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sdmb_core #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (item_valid && advance),
      .item   (item),
      .result (result)
   );

   sdmb_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_status            = rsp_item.status;
   assign rsp_issue_block       = rsp_item.issue_block;
   assign rsp_issue_write       = rsp_item.issue_write;
   assign rsp_command_argument  = rsp_item.command_argument;
   assign rsp_dma_base          = rsp_item.dma_base;
   assign rsp_transfer_finished = rsp_item.transfer_finished;
   assign rsp_mode_now          = rsp_item.mode_now;

endmodule

`default_nettype wire

// ===== hdl/sdmb_checker.sv =====
// ----------------------------------------------------------------------------
// sdmb_checker: port-level assertions for the sequencer
// Checks response consistency seen at the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_issue_block,
   input wire logic        rsp_issue_write,
   input wire logic [31:0] rsp_command_argument,
   input wire logic [31:0] rsp_dma_base,
   input wire logic        rsp_transfer_finished,
   input wire logic [2:0]  rsp_mode_now
);
   import sdmb_pkg::*;

   // A stalled response transfer stays and keeps its status, DMA base and mode.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_dma_base) && $stable(rsp_mode_now))
      else $error("response changed while stalled");

   // Without an issued block, the issue fields read as zero.
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_issue_block |-> !rsp_issue_write &&
                                        rsp_command_argument == 32'd0 &&
                                        rsp_dma_base == 32'd0)
      else $error("issue fields nonzero without an issued block");

   // An issued block is reported ok and leaves the unit transferring.
   a_issue_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issue_block |-> rsp_status == ST_OK &&
         (rsp_mode_now == MODE_CODE_SENDING || rsp_mode_now == MODE_CODE_READING) &&
         (rsp_issue_write == (rsp_mode_now == MODE_CODE_SENDING)))
      else $error("issued block with wrong status or mode");

   // A finished transfer issues nothing and reports the finished mode.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transfer_finished |-> !rsp_issue_block &&
         rsp_status == ST_OK && rsp_mode_now == MODE_CODE_FINISH)
      else $error("finished transfer with inconsistent fields");

endmodule

bind sd_multiblock_dma_sequencer_unit sdmb_checker u_sdmb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_status            (rsp_status),
   .rsp_issue_block       (rsp_issue_block),
   .rsp_issue_write       (rsp_issue_write),
   .rsp_command_argument  (rsp_command_argument),
   .rsp_dma_base          (rsp_dma_base),
   .rsp_transfer_finished (rsp_transfer_finished),
   .rsp_mode_now          (rsp_mode_now)
);

`default_nettype wire

// ===== sim/sdmb_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// sdmb_scoreboard_pkg: expected-response tracking for the SD sequencer bench
// Holds a cycle-free model of the multi-block sequencer. Each accepted
// request is run through the model and its response is queued. Each response
// seen on the DUT is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
package sdmb_scoreboard_pkg;

   import sdmb_pkg::*;

   // Configuration register indexes on the csr channel.
   localparam logic CSR_CARD_BLOCKS     = 1'b0;
   localparam logic CSR_BYTE_ADDRESSING = 1'b1;

   // Bytes per card block, both for buffer stepping and argument scaling.
   localparam logic [31:0] SECTOR_BYTES = 32'd512;

   class sequencer_scoreboard;

      rsp_item_type expected_responses[$];

      // Register copies.
      logic [31:0] card_blocks;
      logic        byte_addressing;

      // Transfer state after the last accepted request.
      logic [2:0]  mode;
      logic [31:0] blocks_left;
      logic [31:0] block_now;
      logic [31:0] buffer_now;

      int unsigned error_count;
      int unsigned checked_count;
      int unsigned issued_count;
      int unsigned finished_count;

      function new();
         card_blocks     = '0;
         byte_addressing = 1'b0;
         clear_transfer();
         error_count     = 0;
         checked_count   = 0;
         issued_count    = 0;
         finished_count  = 0;
      endfunction

      function void clear_transfer();
         mode        = MODE_CODE_IDLE;
         blocks_left = '0;
         block_now   = '0;
         buffer_now  = '0;
      endfunction

      function void write_register(input logic index, input logic [31:0] data);
         if (index == CSR_CARD_BLOCKS) begin
            card_blocks = data;
         end else begin
            byte_addressing = data[0];
         end
      endfunction

      // Fill in the single-block command for the current block.
      function void fill_block_command(inout rsp_item_type rsp);
         logic [31:0] scaled;
         scaled                = block_now * SECTOR_BYTES;
         rsp.issue_block      = 1'b1;
         rsp.issue_write      = (mode == MODE_CODE_SENDING);
         rsp.command_argument = byte_addressing ? scaled : block_now;
         rsp.dma_base         = buffer_now;
      endfunction

      // Advance the model by one accepted request and queue its response.
      function void note_request(input req_item_type req);
         rsp_item_type rsp;
         logic [32:0]  range_end;
         rsp        = '0;
         rsp.status = ST_NO_ACTION;
         range_end  = {1'b0, req.block_address} + {1'b0, req.block_count};
         case (req.command)
            CMD_START_WRITE, CMD_START_READ: begin
               // Argument checks come ahead of the busy check.
               if (req.buffer_address == '0 || req.block_count == '0 ||
                   range_end > {1'b0, card_blocks}) begin
                  rsp.status = ST_ARG_ERROR;
               end else if (mode != MODE_CODE_IDLE && mode != MODE_CODE_FINISH) begin
                  rsp.status = ST_BUSY;
               end else begin
                  mode        = (req.command == CMD_START_WRITE) ?
                                MODE_CODE_SENDING : MODE_CODE_READING;
                  blocks_left = req.block_count;
                  block_now   = req.block_address;
                  buffer_now  = req.buffer_address;
                  fill_block_command(rsp);
                  rsp.status  = ST_OK;
               end
            end
            CMD_BLOCK_DONE: begin
               // A completion outside a transfer is ignored.
               if (mode == MODE_CODE_SENDING || mode == MODE_CODE_READING) begin
                  if (blocks_left <= 32'd1) begin
                     clear_transfer();
                     mode                  = MODE_CODE_FINISH;
                     rsp.transfer_finished = 1'b1;
                  end else begin
                     blocks_left = blocks_left - 32'd1;
                     block_now   = block_now + 32'd1;
                     buffer_now  = buffer_now + SECTOR_BYTES;
                     fill_block_command(rsp);
                  end
                  rsp.status = ST_OK;
               end
            end
            CMD_XFER_ERROR: begin
               mode       = MODE_CODE_ERROR;
               rsp.status = ST_OK;
            end
            CMD_RESET: begin
               clear_transfer();
               rsp.status = ST_OK;
            end
            default: begin
            end
         endcase
         rsp.mode_now = mode;
         if (rsp.issue_block) issued_count++;
         if (rsp.transfer_finished) finished_count++;
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(input string field_name, input logic [31:0] want,
                                  input logic [31:0] seen);
         if (want !== seen) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field_name, want, seen);
            error_count++;
         end
      endfunction

      // Compare one response transfer with the oldest expectation.
      function void check_response(input rsp_item_type seen);
         rsp_item_type want;
         if (expected_responses.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
            return;
         end
         want = expected_responses.pop_front();
         checked_count++;
         compare_field("status", 32'(want.status), 32'(seen.status));
         compare_field("issue_block", 32'(want.issue_block), 32'(seen.issue_block));
         compare_field("issue_write", 32'(want.issue_write), 32'(seen.issue_write));
         compare_field("command_argument", want.command_argument, seen.command_argument);
         compare_field("dma_base", want.dma_base, seen.dma_base);
         compare_field("transfer_finished", 32'(want.transfer_finished),
                       32'(seen.transfer_finished));
         compare_field("mode_now", 32'(want.mode_now), 32'(seen.mode_now));
      endfunction

      function int unsigned pending();
         return expected_responses.size();
      endfunction

   endclass

endpackage

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the SD multi-block DMA sequencer
// A directed run covers the start checks, busy refusal, wrap of buffer and
// argument, finish, error and reset. Random phases under several register
// settings then run mostly well-formed transfers mixed with stray events,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   import sdmb_pkg::*;
   import sdmb_scoreboard_pkg::*;

   localparam logic [2:0]  CMD_UNDEFINED   = 3'd7;
   localparam int unsigned ITEMS_PER_PHASE = 235;
   localparam int unsigned PHASE_COUNT     = 8;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = CMD_RESET;
   logic [31:0] req_buffer_address = '0;
   logic [31:0] req_block_address = '0;
   logic [31:0] req_block_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_issue_block;
   logic        rsp_issue_write;
   logic [31:0] rsp_command_argument;
   logic [31:0] rsp_dma_base;
   logic        rsp_transfer_finished;
   logic [2:0]  rsp_mode_now;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_CARD_BLOCKS;
   logic [31:0] csr_data = '0;

   sequencer_scoreboard tracker = new();
   rsp_item_type        seen_response;
   int unsigned         cycle_count = 0;
   int unsigned         requests_sent = 0;
   int unsigned         settings_used = 0;
   int unsigned         gap_odds = 0;
   int unsigned         stall_odds = 0;

   sd_multiblock_dma_sequencer_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_buffer_address   (req_buffer_address),
      .req_block_address    (req_block_address),
      .req_block_count      (req_block_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_issue_block      (rsp_issue_block),
      .rsp_issue_write      (rsp_issue_write),
      .rsp_command_argument (rsp_command_argument),
      .rsp_dma_base         (rsp_dma_base),
      .rsp_transfer_finished(rsp_transfer_finished),
      .rsp_mode_now         (rsp_mode_now),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog against a hung handshake.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("sd_multiblock_dma_sequencer_unit verification failed");
      $finish;
   end

   // Response monitor: every response transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_response.status            = rsp_status;
         seen_response.issue_block       = rsp_issue_block;
         seen_response.issue_write       = rsp_issue_write;
         seen_response.command_argument  = rsp_command_argument;
         seen_response.dma_base          = rsp_dma_base;
         seen_response.transfer_finished = rsp_transfer_finished;
         seen_response.mode_now          = rsp_mode_now;
         tracker.check_response(seen_response);
      end
   end

   // Receiver stalls come in bursts of random length.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_odds != 0 && $urandom_range(stall_odds, 1) == 1) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(13, 1)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Drive one request and return at the edge where it transfers.
   task automatic send_request(input logic [2:0] command, input logic [31:0] buffer_addr,
                               input logic [31:0] block_addr, input logic [31:0] count);
      req_item_type req;
      if (gap_odds != 0 && $urandom_range(gap_odds, 1) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= command;
      req_buffer_address <= buffer_addr;
      req_block_address  <= block_addr;
      req_block_count    <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req.command        = command;
      req.buffer_address = buffer_addr;
      req.block_address  = block_addr;
      req.block_count    = count;
      tracker.note_request(req);
      requests_sent++;
   endtask

   // Wait until every expected response has come back, then let the pipe settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both configuration registers back to back.
   task automatic write_config(input logic [31:0] card_blocks, input logic byte_mode);
      csr_valid <= 1'b1;
      csr_index <= CSR_CARD_BLOCKS;
      csr_data  <= card_blocks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(CSR_CARD_BLOCKS, card_blocks);
      csr_index <= CSR_BYTE_ADDRESSING;
      csr_data  <= {31'd0, byte_mode};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(CSR_BYTE_ADDRESSING, {31'd0, byte_mode});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Pick start arguments that pass the range check unless the card holds no blocks.
   task automatic pick_start(output logic [31:0] buffer_addr, output logic [31:0] block_addr,
                             output logic [31:0] count);
      logic [31:0] room;
      logic [63:0] span;
      count = ($urandom_range(9, 0) == 0) ? $urandom : 32'($urandom_range(6, 1));
      if (tracker.card_blocks != '0 && count > tracker.card_blocks) begin
         count = tracker.card_blocks;
      end
      room = (tracker.card_blocks >= count) ? tracker.card_blocks - count : '0;
      span = {32'd0, room} + 64'd1;
      block_addr = ($urandom_range(3, 0) == 0) ? room : 32'(({32'd0, $urandom}) % span);
      buffer_addr = ($urandom_range(3, 0) == 0) ? ($urandom | 32'hFFFF_F000) : $urandom;
      if (buffer_addr == '0) buffer_addr = 32'd1;
   endtask

   // One stray event in the middle of a transfer.
   task automatic send_disturbance();
      logic [31:0] buffer_addr;
      logic [31:0] block_addr;
      logic [31:0] count;
      pick_start(buffer_addr, block_addr, count);
      case ($urandom_range(5, 0))
         0: send_request($urandom_range(1, 0) ? CMD_START_READ : CMD_START_WRITE,
                         buffer_addr, block_addr, count);
         1: send_request(CMD_START_WRITE, $urandom_range(1, 0) ? 32'd0 : buffer_addr,
                         block_addr, $urandom_range(1, 0) ? count : 32'd0);
         2: send_request(3'($urandom_range(CMD_UNDEFINED, CMD_RESET + 1)),
                         $urandom, $urandom, $urandom);
         3: send_request(CMD_XFER_ERROR, $urandom, $urandom, $urandom);
         4: send_request(CMD_RESET, $urandom, $urandom, $urandom);
         default: send_request(CMD_BLOCK_DONE, $urandom, $urandom, $urandom);
      endcase
   endtask

   // Mostly complete transfers with random content, with some noise mixed in.
   task automatic run_sequence();
      logic [31:0] buffer_addr;
      logic [31:0] block_addr;
      logic [31:0] count;
      int unsigned done_events;
      if ($urandom_range(4, 0) == 0) begin
         send_request(3'($urandom_range(CMD_UNDEFINED, 0)),
                      $urandom_range(3, 0) == 0 ? 32'd0 : $urandom,
                      $urandom, $urandom_range(3, 0) == 0 ? 32'd0 : $urandom);
         return;
      end
      pick_start(buffer_addr, block_addr, count);
      send_request($urandom_range(1, 0) ? CMD_START_READ : CMD_START_WRITE,
                   buffer_addr, block_addr, count);
      done_events = (count <= 32'd6) ? int'(count) + $urandom_range(1, 0)
                                     : $urandom_range(8, 1);
      for (int unsigned i = 0; i < done_events; i++) begin
         if ($urandom_range(9, 0) == 0) send_disturbance();
         send_request(CMD_BLOCK_DONE, $urandom, $urandom, $urandom);
      end
      // Leave stuck transfers and the error mode behind most of the time.
      if (tracker.mode != MODE_CODE_IDLE && tracker.mode != MODE_CODE_FINISH &&
          $urandom_range(3, 0) != 0) begin
         send_request(CMD_RESET, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      logic [31:0] phase_blocks;
      logic        phase_byte_mode;
      int unsigned phase_target;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset value: the card holds no blocks.
      send_request(CMD_START_WRITE, 32'h0000_1000, 32'd0, 32'd1);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      wait_for_idle();

      // Directed cases on the largest card with byte addressing.
      write_config(32'hFFFF_FFFF, 1'b1);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_START_WRITE, 32'd0, 32'd5, 32'd1);
      send_request(CMD_START_READ, 32'h100, 32'd5, 32'd0);
      // The range sum must not wrap to pass the check.
      send_request(CMD_START_WRITE, 32'h100, 32'hFFFF_FFFF, 32'd2);
      send_request(CMD_START_WRITE, 32'hFFFF_FF00, 32'hFFFF_FFFE, 32'd1);
      send_request(CMD_START_READ, 32'h200, 32'd0, 32'd1);
      send_request(CMD_START_READ, 32'd0, 32'd0, 32'd1);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      // Buffer address wraps on the second block.
      send_request(CMD_START_WRITE, 32'hFFFF_FE00, 32'h0080_0000, 32'd3);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_START_READ, 32'd1, 32'd0, 32'hFFFF_FFFF);
      send_request(CMD_BLOCK_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(CMD_XFER_ERROR, '0, '0, '0);
      send_request(CMD_BLOCK_DONE, '0, '0, '0);
      send_request(CMD_START_WRITE, 32'h400, 32'd1, 32'd1);
      send_request(CMD_XFER_ERROR, '0, '0, '0);
      send_request(CMD_RESET, '0, '0, '0);
      send_request(CMD_UNDEFINED, '0, '0, '0);
      send_request(CMD_START_WRITE, 32'hFFFF_FFFF, 32'd0, 32'd1);
      send_request(CMD_RESET, '0, '0, '0);
      wait_for_idle();

      // Random phases, each under its own register setting.
      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin phase_blocks = 32'd0;        phase_byte_mode = 1'b0; end
            1: begin phase_blocks = 32'hFFFF_FFFF; phase_byte_mode = 1'b0; end
            2: begin phase_blocks = 32'hFFFF_FFFF; phase_byte_mode = 1'b1; end
            3: begin phase_blocks = 32'd16;       phase_byte_mode = 1'b1; end
            4: begin phase_blocks = $urandom;     phase_byte_mode = 1'b0; end
            5: begin phase_blocks = $urandom;     phase_byte_mode = 1'b1; end
            6: begin phase_blocks = 32'd1;        phase_byte_mode = 1'($urandom); end
            default: begin phase_blocks = $urandom; phase_byte_mode = 1'($urandom); end
         endcase
         write_config(phase_blocks, phase_byte_mode);
         // The last phase runs with no idling at all.
         if (phase == PHASE_COUNT - 1) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = $urandom_range(5, 0);
            stall_odds = $urandom_range(5, 0);
         end
         phase_target = requests_sent + ITEMS_PER_PHASE;
         while (requests_sent < phase_target) run_sequence();
         wait_for_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d requests under %0d register settings; %0d responses checked.",
               requests_sent, settings_used, tracker.checked_count);
      $display("Blocks issued: %0d, transfers finished: %0d.",
               tracker.issued_count, tracker.finished_count);
      if (tracker.error_count == 0 && tracker.pending() == 0) begin
         $display("sd_multiblock_dma_sequencer_unit verification clean");
      end else begin
         $display("sd_multiblock_dma_sequencer_unit verification failed");
      end
      $finish;
   end

endmodule
